FILE: rtl/ols_pkg.sv
// ols_pkg: shared types and codes for the ordered list store.
// Used by the front end, the list engine and the top level.
`timescale 1ns / 1ps
package ols_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 6;
  localparam int unsigned MaxDump = 32;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 3'd0,
    KIND_DELVAL = 3'd1,
    KIND_DELMIN = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_DUMP   = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // Classified operation handed from the front end to the engine
  typedef enum logic [2:0] {
    OP_APPEND,
    OP_DELVAL,
    OP_DELMIN,
    OP_CLEAR,
    OP_DUMP,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DataW-1:0]  value;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DUMP,
    S_RESULT
  } eng_state_e;

endpackage

FILE: rtl/ordered_list_store.sv
// ordered_list_store: top level joining the command front end and the list engine.
// Depends on ols_pkg, ols_front and ols_engine.
`timescale 1ns / 1ps
// An ordered list of up to DEPTH signed 32-bit values in insertion order.
// Append, clear and unused kinds go straight to the result. Delete-value and
// delete-smallest read the list memory once per entry searched (one read port),
// then shift later entries down one slot per cycle. A dump reads each entry
// before emitting it, waits while the output is stalled, and emits at most 32.
// Up to two commands queue ahead of the engine. No clearing pass after reset.
module ordered_list_store import ols_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [DataW-1:0]   value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [DataW-1:0]   entry_o,
  output logic [LenW-1:0]    length_o,
  output logic               last_o
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  ols_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .value_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  ols_engine #(.DEPTH(DEPTH)) u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .status_o, .entry_o, .length_o, .last_o
  );

`ifndef SYNTHESIS
  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> cmd_valid) else $error("command taken from empty queue");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_o) && $stable(last_o))
    else $error("stalled result changed");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DEPTH < 64 |-> length_o <= LenW'(DEPTH)) else $error("length beyond depth");
`endif

endmodule

FILE: rtl/ols_front.sv
// ols_front: accepts input items, decodes the kind and queues commands.
// Depends on ols_pkg.
`timescale 1ns / 1ps
module ols_front import ols_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [DataW-1:0] value_i,
  output logic             cmd_valid_o,
  input  logic             cmd_take_i,
  output cmd_t             cmd_o
);

  // Two-entry command queue
  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_new;

  // Classify the kind
  always_comb begin
    cmd_new.value = value_i;
    unique case (kind_i)
      KIND_APPEND: cmd_new.op = OP_APPEND;
      KIND_DELVAL: cmd_new.op = OP_DELVAL;
      KIND_DELMIN: cmd_new.op = OP_DELMIN;
      KIND_CLEAR:  cmd_new.op = OP_CLEAR;
      KIND_DUMP:   cmd_new.op = OP_DUMP;
      default:     cmd_new.op = OP_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_new;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/ols_engine.sv
// ols_engine: holds the list memory and carries out one command at a time.
// Depends on ols_pkg.
`timescale 1ns / 1ps
module ols_engine import ols_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_take_o,
  input  cmd_t               cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [DataW-1:0]   entry_o,
  output logic [LenW-1:0]    length_o,
  output logic               last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] DumpMaxC = (DEPTH > MaxDump) ? CW'(MaxDump) : CW'(DEPTH);

  logic [DataW-1:0] mem [DEPTH];

  eng_state_e state_q, state_d;
  cmd_t       cmd_q;
  logic [CW-1:0] occ_q, occ_d;
  logic [CW-1:0] idx_q, idx_d;       // read address of the issued read
  logic [CW-1:0] pos_q, pos_d;       // position being compared or written
  logic          rd_vld_q, rd_vld_d; // read data valid next cycle
  logic [DataW-1:0] rdata_q;
  logic [CW-1:0] best_q, best_d;
  logic [DataW-1:0] bestv_q, bestv_d;
  logic          found_q, found_d;
  logic [CW-1:0] dump_n_q, dump_n_d;

  // Output register
  logic               ovld_q, ovld_d;
  logic [StatusW-1:0] ost_q, ost_d;
  logic [DataW-1:0]   oent_q, oent_d;
  logic               olast_q, olast_d;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [DataW-1:0] mem_wd;
  logic             out_free;

  assign out_free = !ovld_q || !out_stall_i;

  // Memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[idx_q[AW-1:0]];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_DELVAL, OP_DELMIN: state_d = (occ_q == '0) ? S_RESULT : S_SEARCH;
            OP_DUMP:              state_d = (occ_q == '0) ? S_RESULT : S_DUMP;
            default:              state_d = S_RESULT;
          endcase
        end
      end
      S_SEARCH: if (rd_vld_q && pos_q + 1'b1 >= occ_q) begin
        if (cmd_q.op == OP_DELMIN || found_d) state_d = S_SHIFT;
        else state_d = S_RESULT;
      end else if (cmd_q.op == OP_DELVAL && found_d) begin
        state_d = S_SHIFT;
      end
      S_SHIFT: if (pos_q + 1'b1 >= occ_q || (rd_vld_q && pos_q + 2'd2 >= occ_q))
        state_d = S_RESULT;
      S_DUMP: if (out_free && rd_vld_q && pos_q + 1'b1 >= dump_n_q) state_d = S_IDLE;
      S_RESULT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    occ_d = occ_q; idx_d = idx_q; pos_d = pos_q; rd_vld_d = 1'b0;
    best_d = best_q; bestv_d = bestv_q; found_d = found_q; dump_n_d = dump_n_q;
    mem_we = 1'b0; mem_wa = pos_q[AW-1:0]; mem_wd = rdata_q;
    ovld_d = ovld_q && out_stall_i; ost_d = ost_q; oent_d = oent_q; olast_d = olast_q;
    cmd_take_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // First read of the list is issued in the next state
        cmd_take_o = cmd_valid_i;
        idx_d = '0; pos_d = '0; found_d = 1'b0; best_d = '0;
        dump_n_d = (occ_q > DumpMaxC) ? DumpMaxC : occ_q;
      end
      S_SEARCH: begin
        // One compare per cycle against registered read data
        if (rd_vld_q) begin
          if (cmd_q.op == OP_DELVAL) begin
            if (rdata_q == cmd_q.value) begin
              found_d = 1'b1; best_d = pos_q; bestv_d = rdata_q;
            end
          end else if (pos_q == '0 || $signed(rdata_q) < $signed(bestv_q)) begin
            best_d = pos_q; bestv_d = rdata_q; found_d = 1'b1;
          end
          pos_d = pos_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        rd_vld_d = 1'b1;
        if (state_d == S_SHIFT) begin
          // Begin closing the gap at the removed slot
          pos_d = best_d; idx_d = best_d + 1'b1; rd_vld_d = 1'b0;
        end
      end
      S_SHIFT: begin
        // Move each later entry down by one slot
        idx_d = idx_q + 1'b1;
        rd_vld_d = 1'b1;
        if (rd_vld_q) begin
          mem_we = 1'b1; pos_d = pos_q + 1'b1;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          if (rd_vld_q) begin
            ovld_d = 1'b1; ost_d = ST_DONE; oent_d = rdata_q;
            olast_d = (pos_q + 1'b1 >= dump_n_q);
            pos_d = pos_q + 1'b1;
            idx_d = idx_q + 1'b1;
            rd_vld_d = 1'b0;
          end else begin
            rd_vld_d = 1'b1;
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          ovld_d = 1'b1; olast_d = 1'b1; oent_d = '0; ost_d = ST_DONE;
          unique case (cmd_q.op)
            OP_APPEND: if (occ_q >= DepthC) ost_d = ST_FULL;
                       else begin
                         mem_we = 1'b1; mem_wa = occ_q[AW-1:0]; mem_wd = cmd_q.value;
                         occ_d = occ_q + 1'b1;
                       end
            OP_DELVAL, OP_DELMIN: if (found_q && occ_q != '0) begin
                         oent_d = bestv_q; occ_d = occ_q - 1'b1;
                       end else ost_d = ST_NOTFOUND;
            OP_CLEAR:  occ_d = '0;
            OP_DUMP:   ost_d = ST_NOTFOUND;
            default:   ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; occ_q <= '0; ovld_q <= 1'b0; rd_vld_q <= 1'b0;
    end else begin
      state_q <= state_d; occ_q <= occ_d; ovld_q <= ovld_d; rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cmd_q <= cmd_i;
    idx_q <= idx_d; pos_q <= pos_d; best_q <= best_d; bestv_q <= bestv_d;
    found_q <= found_d; dump_n_q <= dump_n_d;
    ost_q <= ost_d; oent_q <= oent_d; olast_q <= olast_d;
  end

  assign out_valid_o = ovld_q;
  assign status_o    = ost_q;
  assign entry_o     = oent_q;
  assign length_o    = LenW'(occ_q);
  assign last_o      = olast_q;

endmodule

FILE: tb/ordered_list_store_test.sv
// ordered_list_store_test: self-checking bench for the ordered list store.
// Drives random and directed list operations, predicts results in a scoreboard
// class; depends on ols_pkg and ordered_list_store.
`timescale 1ns / 1ps
module ordered_list_store_test;
  import ols_pkg::*;

  localparam int unsigned Depth = 32;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   entry;
    logic [LenW-1:0]    length;
    logic               last;
  } list_result_t;

  // Shadow list and queue of pending results
  class list_scoreboard;
    logic [DataW-1:0] shadow[$];
    list_result_t     pending[$];
    int               errors;

    function void push(logic [StatusW-1:0] st, logic [DataW-1:0] e, logic lst);
      list_result_t r;
      r.status = st;
      r.entry  = e;
      r.length = LenW'(shadow.size());
      r.last   = lst;
      pending.push_back(r);
    endfunction

    // Predict the results of one accepted operation
    function void note_transfer(logic [KindW-1:0] kind, logic [DataW-1:0] value);
      int best;
      logic [DataW-1:0] v;
      best = -1;
      case (kind)
        KIND_APPEND: begin
          if (shadow.size() >= Depth) push(ST_FULL, '0, 1'b1);
          else begin
            shadow.push_back(value);
            push(ST_DONE, '0, 1'b1);
          end
        end
        KIND_DELVAL: begin
          foreach (shadow[i]) if (best < 0 && shadow[i] == value) best = i;
          if (best < 0) push(ST_NOTFOUND, '0, 1'b1);
          else begin
            shadow.delete(best);
            push(ST_DONE, value, 1'b1);
          end
        end
        KIND_DELMIN: begin
          if (shadow.size() == 0) push(ST_NOTFOUND, '0, 1'b1);
          else begin
            best = 0;
            foreach (shadow[i])
              if ($signed(shadow[i]) < $signed(shadow[best])) best = i;
            v = shadow[best];
            shadow.delete(best);
            push(ST_DONE, v, 1'b1);
          end
        end
        KIND_CLEAR: begin
          shadow.delete();
          push(ST_DONE, '0, 1'b1);
        end
        KIND_DUMP: begin
          if (shadow.size() == 0) push(ST_NOTFOUND, '0, 1'b1);
          else foreach (shadow[i])
            if (i < MaxDump) push(ST_DONE, shadow[i], i + 1 == shadow.size() || i + 1 == MaxDump);
        end
        default: push(ST_DONE, '0, 1'b1);
      endcase
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(list_result_t got);
      list_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result st=%0d entry=%h len=%0d last=%0b", $time,
                 got.status, got.entry, got.length, got.last);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.entry !== exp_r.entry) begin
        $display("%0t: entry expected %h actual %h", $time, exp_r.entry, got.entry);
        errors++;
      end
      if (got.length !== exp_r.length) begin
        $display("%0t: length expected %0d actual %0d", $time, exp_r.length, got.length);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [KindW-1:0]   kind_i;
  logic [DataW-1:0]   value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [StatusW-1:0] status_o;
  logic [DataW-1:0]   entry_o;
  logic [LenW-1:0]    length_o;
  logic               last_o;

  list_scoreboard sb;
  bit             hold_off_req;
  logic [DataW-1:0] pool[8];

  ordered_list_store #(.DEPTH(Depth)) u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one operation and hold it until the transfer
  task automatic send_op(logic [KindW-1:0] kind, logic [DataW-1:0] value, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(kind, value);
  endtask

  function automatic logic [DataW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return pool[$urandom_range(0, 7)];
    if (r < 7) return 32'h8000_0000;
    if (r < 8) return 32'h7fff_ffff;
    return $urandom();
  endfunction

  function automatic logic [KindW-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return KIND_APPEND;
    if (r < 63) return KIND_DELVAL;
    if (r < 78) return KIND_DELMIN;
    if (r < 82) return KIND_CLEAR;
    if (r < 94) return KIND_DUMP;
    return KindW'($urandom_range(5, 7));
  endfunction

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    list_result_t got;
    int g;
    out_stall_i = 1'b1;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.status = status_o;
        got.entry  = entry_o;
        got.length = length_o;
        got.last   = last_o;
        sb.check_result(got);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        g = gap_len();
        out_stall_i <= (g > 0 && $urandom_range(0, 2) == 0);
      end
    end
  end

  // Stimulus
  initial begin
    int n;
    sb = new();
    in_valid_i   = 1'b0;
    kind_i       = KIND_APPEND;
    value_i      = '0;
    hold_off_req = 1'b0;
    foreach (pool[i]) pool[i] = $urandom_range(0, 15) - 8;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list cases, extremes, ties, full list, unused kinds
    send_op(KIND_DUMP, '0, 0);
    send_op(KIND_DELMIN, '0, 0);
    send_op(KIND_DELVAL, 32'd5, 0);
    send_op(KIND_APPEND, 32'h7fff_ffff, 0);
    send_op(KIND_APPEND, 32'h8000_0000, 0);
    send_op(KIND_APPEND, 32'hffff_ffff, 0);
    send_op(KIND_APPEND, 32'h8000_0000, 0);
    send_op(KIND_DUMP, '0, 0);
    send_op(KIND_DELMIN, '0, 0);
    send_op(KIND_DELVAL, 32'hffff_ffff, 0);
    send_op(KIND_DELVAL, 32'h1234_5678, 0);
    send_op(3'd5, 32'hffff_ffff, 0);
    send_op(3'd7, '0, 0);
    send_op(KIND_CLEAR, '0, 0);
    send_op(KIND_APPEND, 32'h5555_aaaa, 0);
    // Fill the list past full while the receiver holds off
    hold_off_req = 1'b1;
    for (int i = 0; i < 33; i++) send_op(KIND_APPEND, $urandom(), 0);
    send_op(KIND_DUMP, '0, 0);
    send_op(KIND_CLEAR, '0, 0);
    send_op(KIND_DUMP, '0, 0);

    // Random operations over a small value pool so deletes hit
    for (n = 0; n < 300; n++) send_op(pick_kind(), pick_value(), 1);
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
